// ===== rtl/core/arcd_pkg.sv =====
// ----------------------------------------------------------------------------
// arcd_pkg
// types and constants shared by the alert raise/cancel debounce block
// ----------------------------------------------------------------------------
package arcd_pkg;

   localparam int NUM_ALERTS = 32;
   localparam int TIME_BITS  = 48;
   localparam int ADDR_W     = $clog2(NUM_ALERTS);
   localparam int IDX_W      = 5;
   localparam int DELAY_W    = 32;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [2:0] {
      OP_RAISE      = 3'd0,
      OP_RAISE_NOW  = 3'd1,
      OP_CANCEL     = 3'd2,
      OP_CANCEL_NOW = 3'd3,
      OP_TICK       = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_ABSENT   = 3'd0,
      ST_RISING   = 3'd1,
      ST_MAYRISE  = 3'd2,
      ST_RAISED   = 3'd3,
      ST_DROPPING = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      NOTE_NONE     = 2'd0,
      NOTE_RAISED   = 2'd1,
      NOTE_CANCELED = 2'd2
   } notice_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RISE_DELAY    = 2'd0,
      CSR_MAYRISE_DELAY = 2'd1,
      CSR_DROP_DELAY    = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SWEEP,
      FSM_FLUSH
   } fsm_type;

   typedef struct packed {
      logic [2:0]           operation;
      logic [IDX_W-1:0]     alert_index;
      logic [TIME_BITS-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] entry_index;
      logic [2:0]       old_state;
      logic [2:0]       new_state;
      logic             changed;
      logic [1:0]       notice;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [DELAY_W-1:0] rise_delay;
      logic [DELAY_W-1:0] mayrise_delay;
      logic [DELAY_W-1:0] drop_delay;
   } cfg_type;

   typedef struct packed {
      status_type           status;
      logic [TIME_BITS-1:0] rise_time;
      logic [TIME_BITS-1:0] visible_time;
      logic [TIME_BITS-1:0] cancel_time;
   } entry_type;

   typedef struct packed {
      logic       changed;
      status_type old_state;
      status_type new_state;
      notice_type notice;
   } upd_type;

endpackage

// ===== rtl/core/arcd_ram.sv =====
// ----------------------------------------------------------------------------
// arcd_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module arcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/arcd_eval.sv =====
// ----------------------------------------------------------------------------
// arcd_eval
// next value of one alert entry for a request or a sweep step
// ----------------------------------------------------------------------------
module arcd_eval import arcd_pkg::*; (
   input  logic [2:0]           op,
   input  entry_type            entry_q,
   input  logic [TIME_BITS-1:0] now,
   input  cfg_type              cfg,
   output entry_type            entry_d,
   output upd_type              upd
);

   logic [TIME_BITS-1:0] add_base;
   logic [DELAY_W-1:0]   add_delay;
   logic [TIME_BITS:0]   add_sum;
   logic [TIME_BITS-1:0] add_sat;
   logic                 vis_due;
   logic                 cancel_due;
   status_type           olds;
   notice_type           note;

   assign olds = entry_q.status;

   // one shared saturating adder, operands picked by operation
   always_comb begin
      if (op == OP_RAISE) begin
         add_base  = (olds == ST_ABSENT) ? now : entry_q.rise_time;
         add_delay = cfg.rise_delay;
      end else begin
         add_base  = now;
         add_delay = (olds == ST_RISING) ? cfg.mayrise_delay : cfg.drop_delay;
      end
   end

   assign add_sum    = {1'b0, add_base} + (TIME_BITS+1)'(add_delay);
   assign add_sat    = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];
   assign vis_due    = (entry_q.visible_time <= now);
   assign cancel_due = (entry_q.cancel_time <= now);

   always_comb begin
      entry_d = entry_q;
      note    = NOTE_NONE;
      unique case (op)
         OP_RAISE: begin
            if (olds == ST_MAYRISE && vis_due) begin
               entry_d.status       = ST_RAISED;
               entry_d.visible_time = '0;
               note                 = NOTE_RAISED;
            end else if (olds == ST_MAYRISE || olds == ST_ABSENT) begin
               if (olds == ST_ABSENT) begin
                  entry_d.rise_time = now;
               end
               entry_d.visible_time = add_sat;
               entry_d.status       = ST_RISING;
            end else if (olds == ST_DROPPING) begin
               entry_d.status      = ST_RAISED;
               entry_d.cancel_time = '0;
            end
         end
         OP_RAISE_NOW: begin
            if (olds == ST_ABSENT || olds == ST_RISING || olds == ST_MAYRISE) begin
               if (olds == ST_ABSENT) begin
                  entry_d.rise_time = now;
               end
               entry_d.status       = ST_RAISED;
               entry_d.visible_time = '0;
               note                 = NOTE_RAISED;
            end else if (olds == ST_DROPPING) begin
               entry_d.status      = ST_RAISED;
               entry_d.cancel_time = '0;
            end
         end
         OP_CANCEL: begin
            if (olds == ST_RISING) begin
               entry_d.status      = ST_MAYRISE;
               entry_d.cancel_time = add_sat;
            end else if (olds == ST_RAISED) begin
               entry_d.status      = ST_DROPPING;
               entry_d.cancel_time = add_sat;
            end
         end
         OP_CANCEL_NOW: begin
            if (olds == ST_RISING || olds == ST_MAYRISE) begin
               entry_d.status = ST_ABSENT;
            end else if (olds == ST_RAISED || olds == ST_DROPPING) begin
               entry_d.status = ST_ABSENT;
               note           = NOTE_CANCELED;
            end
         end
         OP_TICK: begin
            if (olds == ST_RISING || olds == ST_MAYRISE) begin
               if (vis_due) begin
                  entry_d.status       = ST_RAISED;
                  entry_d.visible_time = '0;
                  note                 = NOTE_RAISED;
               end else if (olds == ST_MAYRISE && cancel_due) begin
                  entry_d.status = ST_ABSENT;
               end
            end else if (olds == ST_DROPPING && cancel_due) begin
               entry_d.status = ST_ABSENT;
               note           = NOTE_CANCELED;
            end
         end
         default: begin
            entry_d = entry_q;
         end
      endcase
   end

   assign upd.changed   = (entry_d.status != olds);
   assign upd.old_state = olds;
   assign upd.new_state = entry_d.status;
   assign upd.notice    = note;

endmodule

// ===== rtl/core/alert_raise_cancel_debounce.sv =====
// ----------------------------------------------------------------------------
// alert_raise_cancel_debounce
// table of alert entries moved by raise/cancel requests and swept by ticks
// ----------------------------------------------------------------------------
// A raise, raise-now, cancel or cancel-now request reads its entry from the
// entry ram in the cycle of acceptance and modifies and writes it back in the
// next, so busy is high for one cycle, and the single result goes out through
// the result register on rsp_strobe. A tick keeps busy high through a sweep
// and a flush state: one ram read per entry in index order, each entry
// evaluated and written back in turn, then the flush sends the final result.
// Each changed entry gives one result; a result is held back one change so
// that the final one can carry last, and a tick with no change gives none.
// Operation codes 5 to 7 are taken and dropped with no result. Results are
// shown for exactly one cycle and cannot be held off by the receiver. Entry
// status comes out of reset as absent through per-entry valid flops, so there
// is no clearing pass. Delay registers may be written at any idle time.
// ----------------------------------------------------------------------------
module alert_raise_cancel_debounce import arcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DELAY_W-1:0]   csr_wdata
);

   // control state
   fsm_type               state_ff, state_in;
   logic [NUM_ALERTS-1:0] valid_ff, valid_in;
   cfg_type               cfg_ff, cfg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  rd_valid_ff, rd_valid_in;

   // payload registers
   logic [2:0]            op_ff, op_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [ADDR_W-1:0]     eval_idx_ff, eval_idx_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   rsp_type               pend_ff, pend_in;

   // ram side
   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   entry_type             rd_entry, entry_q, entry_d;
   upd_type               upd;

   logic                  accept;
   logic                  is_tick;
   logic                  is_request;
   logic                  idx_ok;
   logic                  sweep_end;
   rsp_type               upd_rsp;

   assign accept     = start && !busy;
   assign is_tick    = (req_data.operation == OP_TICK);
   assign is_request = (req_data.operation == OP_RAISE)
                    || (req_data.operation == OP_RAISE_NOW)
                    || (req_data.operation == OP_CANCEL)
                    || (req_data.operation == OP_CANCEL_NOW);
   assign idx_ok     = (int'(idx_ff) < NUM_ALERTS);
   assign sweep_end  = (eval_idx_ff == ADDR_W'(NUM_ALERTS - 1));

   // entry ram: status and the three times of each alert in one word
   arcd_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_ALERTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry_d),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // never-written entries read as absent
   always_comb begin
      entry_q = rd_entry;
      if (!rd_valid_ff) begin
         entry_q.status = ST_ABSENT;
      end
   end

   arcd_eval u_eval (
      .op      (op_ff),
      .entry_q (entry_q),
      .now     (now_ff),
      .cfg     (cfg_ff),
      .entry_d (entry_d),
      .upd     (upd)
   );

   // result built from the evaluated entry
   always_comb begin
      upd_rsp.entry_index = (state_ff == FSM_SWEEP) ? IDX_W'(eval_idx_ff) : idx_ff;
      upd_rsp.old_state   = upd.old_state;
      upd_rsp.new_state   = upd.new_state;
      upd_rsp.changed     = upd.changed;
      upd_rsp.notice      = upd.notice;
      upd_rsp.last        = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && is_tick) begin
               state_in = FSM_SWEEP;
            end else if (accept && is_request) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
         end
         FSM_SWEEP: begin
            if (sweep_end) begin
               state_in = FSM_FLUSH;
            end
         end
         FSM_FLUSH: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = eval_idx_ff + 1'b1;
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      eval_idx_in   = eval_idx_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               op_in  = req_data.operation;
               idx_in = req_data.alert_index;
               now_in = req_data.now_ms;
               if (is_tick) begin
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  eval_idx_in   = '0;
                  pend_valid_in = 1'b0;
               end else if (is_request) begin
                  rd_en   = 1'b1;
                  rd_addr = req_data.alert_index[ADDR_W-1:0];
               end
            end
         end
         FSM_EXEC: begin
            wr_en        = idx_ok;
            wr_addr      = idx_ff[ADDR_W-1:0];
            rsp_valid_in = 1'b1;
            if (idx_ok) begin
               rsp_data_in = upd_rsp;
            end else begin
               // index beyond the table: ignored, reported as absent
               rsp_data_in.entry_index = idx_ff;
               rsp_data_in.old_state   = ST_ABSENT;
               rsp_data_in.new_state   = ST_ABSENT;
               rsp_data_in.changed     = 1'b0;
               rsp_data_in.notice      = NOTE_NONE;
            end
            rsp_data_in.last = 1'b1;
         end
         FSM_SWEEP: begin
            wr_en = 1'b1;
            if (upd.changed) begin
               // send the held result, keep this one until the next change
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_ff;
               end
               pend_in       = upd_rsp;
               pend_valid_in = 1'b1;
            end
            if (!sweep_end) begin
               rd_en       = 1'b1;
               eval_idx_in = eval_idx_ff + 1'b1;
            end
         end
         FSM_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = pend_ff;
               rsp_data_in.last = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
      endcase
   end

   // valid flags and the read-side copy of the addressed one
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;

   // delay registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RISE_DELAY:    cfg_in.rise_delay    = csr_wdata;
            CSR_MAYRISE_DELAY: cfg_in.mayrise_delay = csr_wdata;
            CSR_DROP_DELAY:    cfg_in.drop_delay    = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         valid_ff      <= '0;
         cfg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cfg_ff        <= cfg_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      eval_idx_ff <= eval_idx_in;
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== rtl/core/arcd_checker.sv =====
// ----------------------------------------------------------------------------
// arcd_checker
// port-level checks of the alert raise/cancel debounce block
// ----------------------------------------------------------------------------
module arcd_checker import arcd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic req_acc;

   assign req_acc = start && !busy
                 && (req_data.operation == OP_RAISE
                  || req_data.operation == OP_RAISE_NOW
                  || req_data.operation == OP_CANCEL
                  || req_data.operation == OP_CANCEL_NOW);

   // a request gives its single result, marked last, for the same entry
   a_req_result: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##2 (rsp_strobe && rsp_data.last
                       && rsp_data.entry_index == $past(req_data.alert_index, 2)))
      else $error("request result missing or misplaced");

   // an unchanged entry reports the same old and new state
   a_unchanged: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.changed) |-> (rsp_data.old_state == rsp_data.new_state))
      else $error("unchanged result with differing states");

   // a raised notice only comes with the raised state
   a_raised_note: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.notice == NOTE_RAISED) |-> (rsp_data.new_state == ST_RAISED))
      else $error("raised notice without raised state");

   // a canceled notice leaves the entry absent
   a_cancel_note: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.notice == NOTE_CANCELED) |-> (rsp_data.new_state == ST_ABSENT))
      else $error("canceled notice without absent state");

   // undefined operation codes are dropped at once
   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation != OP_TICK && !req_acc) |=> !busy)
      else $error("undefined operation kept the block busy");

endmodule

bind alert_raise_cancel_debounce arcd_checker u_arcd_checker (.*);

// ===== dv/tb_alert_raise_cancel_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alert_raise_cancel_debounce
// self-checking bench for the alert raise/cancel debounce table: a queued
// command driver, a result monitor and a cycle-free model of the entry table
// that predicts every update, checked field by field in order of arrival
// ----------------------------------------------------------------------------
module tb_alert_raise_cancel_debounce;
   import arcd_pkg::*;

   localparam int CLOCK_HALF_NS    = 6;
   localparam int RESET_CYCLES     = 4;
   localparam int MAX_TICK_UPDATES = 32;
   localparam int SWEEP_SETTLE     = NUM_ALERTS + 8;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int PHASE_ITEMS      = 90;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED   = 2'd3;
   localparam logic [2:0]           OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0]           OP_UNDEF_LAST  = 3'd7;
   localparam logic [DELAY_W-1:0]   DELAY_MAX      = '1;
   localparam logic [TIME_BITS-1:0] TIME_MAX       = '1;

   // dut connections, every input known from time zero
   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DELAY_W-1:0]   csr_wdata = '0;

   // mirror of the delay registers and of the alert table
   logic [DELAY_W-1:0]   rise_delay_ms;
   logic [DELAY_W-1:0]   mayrise_delay_ms;
   logic [DELAY_W-1:0]   drop_delay_ms;
   status_type           alert_status     [NUM_ALERTS];
   logic [TIME_BITS-1:0] alert_rise_ms    [NUM_ALERTS];
   logic [TIME_BITS-1:0] alert_visible_ms [NUM_ALERTS];
   logic [TIME_BITS-1:0] alert_cancel_ms  [NUM_ALERTS];

   // commands waiting to go out, and entry updates owed by the block
   req_type              requests_to_send  [$];
   rsp_type              alert_updates_due [$];

   // stimulus shaping
   logic [TIME_BITS-1:0] time_cursor;
   int unsigned          time_step_max;
   int unsigned          hot_span;
   int                   items_queued;

   // driver pacing
   int                   send_gap;
   bit                   no_gaps;

   // bookkeeping
   int                   errors;
   int                   requests_accepted;
   int                   ticks_accepted;
   int                   updates_checked;
   int                   settings_applied;
   int                   idle_cycles;

   alert_raise_cancel_debounce u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // table model
   // ---------------------------------------------------------------------------

   // time plus delay, pinned at the top of the time range
   function automatic logic [TIME_BITS-1:0] add_delay(logic [TIME_BITS-1:0] base,
                                                      logic [DELAY_W-1:0]   delay);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, base} + {{(TIME_BITS - DELAY_W + 1){1'b0}}, delay};
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   function automatic rsp_type make_update(logic [IDX_W-1:0] idx, status_type was,
                                           status_type became, notice_type note);
      rsp_type upd;
      upd.entry_index = idx;
      upd.old_state   = was;
      upd.new_state   = became;
      upd.changed     = (was != became);
      upd.notice      = note;
      upd.last        = 1'b0;
      return upd;
   endfunction

   // advance the table by one accepted transaction and queue what it owes
   function automatic void apply_alert_request(req_type item);
      rsp_type              sweep [$];
      rsp_type              upd;
      status_type           was;
      notice_type           note;
      logic [IDX_W-1:0]     idx;
      logic [TIME_BITS-1:0] at_ms;
      int                   i;
      idx   = item.alert_index;
      at_ms = item.now_ms;
      note  = NOTE_NONE;
      if (item.operation == OP_TICK) begin
         ticks_accepted++;
         // index order sweep, capped in number of changes
         for (i = 0; i < NUM_ALERTS && sweep.size() < MAX_TICK_UPDATES; i++) begin
            was = alert_status[i];
            if ((was == ST_RISING || was == ST_MAYRISE) && alert_visible_ms[i] <= at_ms) begin
               alert_status[i]     = ST_RAISED;
               alert_visible_ms[i] = '0;
               sweep.push_back(make_update(IDX_W'(i), was, ST_RAISED, NOTE_RAISED));
            end else if (was == ST_MAYRISE && alert_cancel_ms[i] <= at_ms) begin
               // expired may-rise goes quietly
               alert_status[i] = ST_ABSENT;
               sweep.push_back(make_update(IDX_W'(i), was, ST_ABSENT, NOTE_NONE));
            end else if (was == ST_DROPPING && alert_cancel_ms[i] <= at_ms) begin
               alert_status[i] = ST_ABSENT;
               sweep.push_back(make_update(IDX_W'(i), was, ST_ABSENT, NOTE_CANCELED));
            end
         end
         if (sweep.size() > 0) sweep[sweep.size() - 1].last = 1'b1;
         foreach (sweep[k]) alert_updates_due.push_back(sweep[k]);
      end else if (item.operation < OP_TICK) begin
         if (idx >= NUM_ALERTS) begin
            upd = make_update(idx, ST_ABSENT, ST_ABSENT, NOTE_NONE);
         end else begin
            was = alert_status[idx];
            unique case (op_type'(item.operation))
               OP_RAISE: begin
                  if (was == ST_MAYRISE && alert_visible_ms[idx] <= at_ms) begin
                     alert_status[idx]     = ST_RAISED;
                     alert_visible_ms[idx] = '0;
                     note                  = NOTE_RAISED;
                  end else if (was == ST_MAYRISE || was == ST_ABSENT) begin
                     // a re-raise keeps the original rise time
                     if (was == ST_ABSENT) alert_rise_ms[idx] = at_ms;
                     alert_visible_ms[idx] = add_delay(alert_rise_ms[idx], rise_delay_ms);
                     alert_status[idx]     = ST_RISING;
                  end else if (was == ST_DROPPING) begin
                     alert_status[idx]    = ST_RAISED;
                     alert_cancel_ms[idx] = '0;
                  end
               end
               OP_RAISE_NOW: begin
                  if (was == ST_ABSENT || was == ST_RISING || was == ST_MAYRISE) begin
                     if (was == ST_ABSENT) alert_rise_ms[idx] = at_ms;
                     alert_status[idx]     = ST_RAISED;
                     alert_visible_ms[idx] = '0;
                     note                  = NOTE_RAISED;
                  end else if (was == ST_DROPPING) begin
                     alert_status[idx]    = ST_RAISED;
                     alert_cancel_ms[idx] = '0;
                  end
               end
               OP_CANCEL: begin
                  if (was == ST_RISING) begin
                     alert_status[idx]    = ST_MAYRISE;
                     alert_cancel_ms[idx] = add_delay(at_ms, mayrise_delay_ms);
                  end else if (was == ST_RAISED) begin
                     alert_status[idx]    = ST_DROPPING;
                     alert_cancel_ms[idx] = add_delay(at_ms, drop_delay_ms);
                  end
               end
               default: begin
                  if (was == ST_RISING || was == ST_MAYRISE) begin
                     alert_status[idx] = ST_ABSENT;
                  end else if (was == ST_RAISED || was == ST_DROPPING) begin
                     alert_status[idx] = ST_ABSENT;
                     note              = NOTE_CANCELED;
                  end
               end
            endcase
            upd = make_update(idx, was, alert_status[idx], note);
         end
         upd.last = 1'b1;
         alert_updates_due.push_back(upd);
      end
      // undefined operation codes are swallowed without an update
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------------

   function automatic void queue_item(logic [2:0] op, logic [IDX_W-1:0] idx,
                                      int unsigned step);
      req_type item;
      time_cursor      = add_delay(time_cursor, step);
      item.operation   = op;
      item.alert_index = idx;
      item.now_ms      = time_cursor;
      requests_to_send.push_back(item);
      items_queued++;
   endfunction

   // half the steps are tiny so that times land exactly on deadlines
   function automatic int unsigned time_step();
      return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2)
                                         : $urandom_range(0, time_step_max);
   endfunction

   function automatic logic [IDX_W-1:0] pick_alert();
      return ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(0, NUM_ALERTS - 1))
                                         : IDX_W'($urandom_range(0, hot_span - 1));
   endfunction

   // raise, cancel, maybe restore, with sweeps mixed in
   function automatic void queue_lifecycle(logic [IDX_W-1:0] idx);
      queue_item(($urandom_range(0, 3) == 0) ? OP_RAISE_NOW : OP_RAISE, idx, time_step());
      if ($urandom_range(0, 1) != 0) queue_item(OP_TICK, pick_alert(), time_step());
      queue_item(OP_CANCEL, idx, time_step());
      if ($urandom_range(0, 2) == 0) queue_item(OP_RAISE, idx, time_step());
      queue_item(OP_TICK, pick_alert(), time_step());
      if ($urandom_range(0, 1) != 0)
         queue_item(($urandom_range(0, 1) != 0) ? OP_CANCEL_NOW : OP_CANCEL, idx, time_step());
   endfunction

   function automatic void queue_noise();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 5)       queue_item(OP_RAISE, pick_alert(), time_step());
      else if (pick < 7)  queue_item(OP_RAISE_NOW, pick_alert(), time_step());
      else if (pick < 12) queue_item(OP_CANCEL, pick_alert(), time_step());
      else if (pick < 14) queue_item(OP_CANCEL_NOW, pick_alert(), time_step());
      else if (pick < 19) queue_item(OP_TICK, pick_alert(), time_step());
      else queue_item(3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)), pick_alert(),
                      time_step());
   endfunction

   // every entry raised then dropped, so one sweep can owe a full table of updates
   function automatic void queue_storm();
      int i;
      for (i = 0; i < NUM_ALERTS; i++) queue_item(OP_RAISE_NOW, IDX_W'(i), 0);
      for (i = 0; i < NUM_ALERTS; i++) queue_item(OP_CANCEL, IDX_W'(i), 0);
      queue_item(OP_TICK, pick_alert(), time_step());
   endfunction

   function automatic void queue_random_phase(int budget);
      int          stop_at;
      int unsigned pick;
      stop_at = items_queued + budget;
      while (items_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)      queue_lifecycle(pick_alert());
         else if (pick < 98) queue_noise();
         else                queue_storm();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // register writes and phase boundaries
   // ---------------------------------------------------------------------------

   // three delay registers back to back, then a write to the unused index
   task automatic program_delays(logic [DELAY_W-1:0] rise, logic [DELAY_W-1:0] mayrise,
                                 logic [DELAY_W-1:0] drop);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_RISE_DELAY;
      csr_wdata <= rise;
      @(posedge clock);
      csr_index <= CSR_MAYRISE_DELAY;
      csr_wdata <= mayrise;
      @(posedge clock);
      csr_index <= CSR_DROP_DELAY;
      csr_wdata <= drop;
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_applied++;
   endtask

   // all commands taken, all updates seen, then room for a silent sweep to end
   task automatic wait_for_idle();
      while (requests_to_send.size() != 0 || start || alert_updates_due.size() != 0)
         @(posedge clock);
      repeat (SWEEP_SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // driver: a transaction is taken at an edge with start high and busy low
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         send_gap =  0;
         no_gaps  =  1'b0;
      end else begin
         if (start && !busy) begin
            apply_alert_request(req_data);
            void'(requests_to_send.pop_front());
            requests_accepted++;
            // occasionally switch between back-to-back and gappy stretches
            if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
            send_gap = no_gaps ? 0 : $urandom_range(0, 3);
         end
         // only one assignment to start per edge; hold while the block is busy
         if (!start || !busy) begin
            if (send_gap > 0) begin
               send_gap--;
               start <= 1'b0;
            end else if (requests_to_send.size() != 0) begin
               start    <= 1'b1;
               req_data <= requests_to_send[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: register mirror and in-order update check
   // ---------------------------------------------------------------------------
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_RISE_DELAY:    rise_delay_ms    <= csr_wdata;
            CSR_MAYRISE_DELAY: mayrise_delay_ms <= csr_wdata;
            CSR_DROP_DELAY:    drop_delay_ms    <= csr_wdata;
            default: ;
         endcase
      end
      if (!reset && rsp_strobe) begin
         if (alert_updates_due.size() == 0) begin
            $error("update for entry %0d with none outstanding", rsp_data.entry_index);
            errors++;
         end else begin
            want = alert_updates_due.pop_front();
            updates_checked++;
            check_field("entry_index", 8'(want.entry_index), 8'(rsp_data.entry_index));
            check_field("old_state",   8'(want.old_state),   8'(rsp_data.old_state));
            check_field("new_state",   8'(want.new_state),   8'(rsp_data.new_state));
            check_field("changed",     8'(want.changed),     8'(rsp_data.changed));
            check_field("notice",      8'(want.notice),      8'(rsp_data.notice));
            check_field("last",        8'(want.last),        8'(rsp_data.last));
         end
      end
   end

   // watchdog on cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("alert_raise_cancel_debounce verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int i;
      // model starts out as the block does after reset
      rise_delay_ms    = '0;
      mayrise_delay_ms = '0;
      drop_delay_ms    = '0;
      for (i = 0; i < NUM_ALERTS; i++) begin
         alert_status[i]     = ST_ABSENT;
         alert_rise_ms[i]    = '0;
         alert_visible_ms[i] = '0;
         alert_cancel_ms[i]  = '0;
      end
      errors            = 0;
      requests_accepted = 0;
      ticks_accepted    = 0;
      updates_checked   = 0;
      settings_applied  = 0;
      items_queued      = 0;
      idle_cycles       = 0;
      time_step_max     = 3;
      hot_span          = 8;
      time_cursor       = 48'd100;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed walk through each state change, small distinct delays
      program_delays(10, 5, 7);
      queue_item(OP_RAISE, 0, 0);          // rising, visible at 110
      queue_item(OP_RAISE, 0, 1);          // raise on rising has no effect
      queue_item(OP_CANCEL, 0, 5);         // may-rise, discard due at 111
      queue_item(OP_RAISE, 0, 0);          // back to rising, same rise time
      queue_item(OP_CANCEL, 0, 1);         // may-rise again
      queue_item(OP_TICK, 0, 3);           // visibility reached exactly: raised
      queue_item(OP_CANCEL, 0, 1);         // dropping, cancel due at 118
      queue_item(OP_RAISE, 0, 1);          // restored from dropping
      queue_item(OP_CANCEL, 0, 1);         // dropping, cancel due at 120
      queue_item(OP_TICK, 0, 7);           // canceled notice on expiry
      queue_item(OP_RAISE_NOW, 31, 1);     // top entry raised at once
      queue_item(OP_RAISE_NOW, 31, 0);     // already raised, nothing to do
      queue_item(OP_CANCEL_NOW, 31, 0);    // canceled at once with notice
      queue_item(OP_RAISE, 5, 1);
      queue_item(OP_CANCEL, 5, 1);         // may-rise with discard before visibility
      queue_item(OP_TICK, 17, 5);          // quiet discard, tick ignores the index
      queue_item(OP_RAISE, 6, 0);
      queue_item(OP_RAISE_NOW, 6, 0);      // immediate raise from rising
      queue_item(OP_RAISE, 8, 0);
      queue_item(OP_CANCEL_NOW, 8, 0);     // immediate cancel of rising, no notice
      queue_item(OP_CANCEL, 9, 0);         // cancels on an absent entry change nothing
      queue_item(OP_CANCEL_NOW, 9, 0);
      queue_item(OP_RAISE, 10, 0);
      queue_item(OP_CANCEL, 10, 0);
      queue_item(OP_RAISE, 10, 10);        // may-rise past visibility raises on request
      queue_item(OP_UNDEF_FIRST, 2, 0);    // unknown code is dropped silently
      wait_for_idle();

      // all delays zero, tight time steps, crowded table
      program_delays('0, '0, '0);
      time_step_max = 3;
      hot_span      = 8;
      queue_random_phase(PHASE_ITEMS);
      queue_storm();
      wait_for_idle();

      // small random delays across the whole table
      program_delays($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40));
      time_step_max = 20;
      hot_span      = NUM_ALERTS;
      queue_random_phase(PHASE_ITEMS);
      wait_for_idle();

      // largest rise delay with instant drop, clock moved into the upper range
      program_delays(DELAY_MAX, $urandom_range(1, 1 << 16), '0);
      time_cursor   = {2'b01, 46'({$urandom, $urandom})};
      time_step_max = 1 << 16;
      hot_span      = 8;
      queue_random_phase(PHASE_ITEMS);
      wait_for_idle();

      // every delay at its maximum close to the end of time, deadlines saturate
      program_delays(DELAY_MAX, DELAY_MAX, DELAY_MAX);
      time_cursor   = TIME_MAX - 48'h2_0000_0000 + $urandom;
      time_step_max = 1 << 28;
      hot_span      = 8;
      queue_random_phase(PHASE_ITEMS);
      wait_for_idle();

      $display("run covered %0d commands (%0d sweeps) over %0d delay settings",
               requests_accepted, ticks_accepted, settings_applied);
      $display("%0d entry updates compared, %0d mismatches", updates_checked, errors);
      if (errors == 0) begin
         $display("alert_raise_cancel_debounce verification clean");
      end else begin
         $display("alert_raise_cancel_debounce verification failed");
      end
      $finish;
   end

endmodule
